/* hw/rtl/assert_macros.svh */
// assertion macros shared by the rtl
// expects i_clk and i_rst_n in the using module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define ASSERT_CLK(label, prop, msg) \
label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
`define ASSERT_CLK_ALWAYS(label, prop, msg) \
label: assert property (@(posedge i_clk) prop) else $error(msg);
`endif

/* hw/rtl/ubhf_pkg.sv */
// types and constants of the bootloader host framer
// no dependencies
package ubhf_pkg;

    localparam logic [2:0] CMD_SYNC        = 3'd0;
    localparam logic [2:0] CMD_GET         = 3'd1;
    localparam logic [2:0] CMD_ERASE       = 3'd2;
    localparam logic [2:0] CMD_START_WRITE = 3'd3;
    localparam logic [2:0] CMD_START_READ  = 3'd4;
    localparam logic [2:0] CMD_WRITE_BYTE  = 3'd5;
    localparam logic [2:0] CMD_TARGET_BYTE = 3'd6;
    localparam logic [2:0] CMD_TICK        = 3'd7;

    localparam logic [1:0] KIND_TX     = 2'd0;
    localparam logic [1:0] KIND_RDATA  = 2'd1;
    localparam logic [1:0] KIND_REQ    = 2'd2;
    localparam logic [1:0] KIND_FINISH = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NACK    = 2'd1;
    localparam logic [1:0] ST_TIMEOUT = 2'd2;
    localparam logic [1:0] ST_UNEXP   = 2'd3;

    localparam logic [2:0] OP_NONE  = 3'd0;
    localparam logic [2:0] OP_SYNC  = 3'd1;
    localparam logic [2:0] OP_GET   = 3'd2;
    localparam logic [2:0] OP_ERASE = 3'd3;
    localparam logic [2:0] OP_WRITE = 3'd4;
    localparam logic [2:0] OP_READ  = 3'd5;

    localparam logic [2:0] REG_ACK     = 3'd0;
    localparam logic [2:0] REG_GET_OP  = 3'd1;
    localparam logic [2:0] REG_READ_OP = 3'd2;
    localparam logic [2:0] REG_WRITE_OP = 3'd3;
    localparam logic [2:0] REG_ERASE_OP = 3'd4;
    localparam logic [2:0] REG_TIMEOUT = 3'd5;

    localparam logic [7:0] SYNC_BYTE = 8'h7F;
    localparam int MAX_RES = 6;

    typedef enum logic [13:0] {
        PH_IDLE        = 14'b00000000000001,
        PH_SYNC_ACK    = 14'b00000000000010,
        PH_GET_ACK     = 14'b00000000000100,
        PH_GET_N       = 14'b00000000001000,
        PH_GET_BODY    = 14'b00000000010000,
        PH_GET_END_ACK = 14'b00000000100000,
        PH_ERASE_ACK1  = 14'b00000001000000,
        PH_ERASE_ACK2  = 14'b00000010000000,
        PH_CMD_ACK     = 14'b00000100000000,
        PH_ADDR_ACK    = 14'b00001000000000,
        PH_RLEN_ACK    = 14'b00010000000000,
        PH_RDATA       = 14'b00100000000000,
        PH_WDATA       = 14'b01000000000000,
        PH_WSUM_ACK    = 14'b10000000000000
    } t_phase;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [31:0] address;
        logic [15:0] length;
        logic [7:0]  data_byte;
    } t_in;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] value;
        logic [8:0] chunk_length;
        logic [1:0] status;
        logic       last;
    } t_out;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] value;
        logic [8:0] chunk_length;
        logic [1:0] status;
    } t_res;

    typedef struct packed {
        logic [2:0] count;
        t_res [MAX_RES-1:0] res;
    } t_pkt;

    typedef struct packed {
        logic [7:0]  ack_value;
        logic [7:0]  get_opcode;
        logic [7:0]  read_opcode;
        logic [7:0]  write_opcode;
        logic [7:0]  erase_opcode;
        logic [15:0] reply_timeout;
    } t_cfg;

endpackage

/* hw/rtl/ubhf_front.sv */
// front part: protocol state, turns each input word into a result packet
// depends on ubhf_pkg
module ubhf_front #(
    parameter int CHUNK_MAX = 256
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  ubhf_pkg::t_cfg  i_cfg,
    input  ubhf_pkg::t_in   i_in,
    input  logic            i_take,
    output ubhf_pkg::t_pkt  o_pkt
);

    ubhf_pkg::t_phase r_phase, n_phase;
    logic [2:0]  r_op, n_op;
    logic [31:0] r_addr, n_addr;
    logic [15:0] r_rem, n_rem;
    logic [8:0]  r_cl, n_cl;
    logic [7:0]  r_sum, n_sum;
    logic [8:0]  r_rc, n_rc;
    logic [7:0]  r_ver, n_ver;
    logic [15:0] r_wt, n_wt;

    function automatic logic [8:0] f_chunk(input logic [15:0] r);
        return (r > 16'(CHUNK_MAX)) ? 9'(CHUNK_MAX) : r[8:0];
    endfunction

    function automatic ubhf_pkg::t_res f_res(input logic [1:0] k, input logic [7:0] v,
                                             input logic [8:0] c, input logic [1:0] s);
        ubhf_pkg::t_res r;
        r.kind = k;
        r.value = v;
        r.chunk_length = c;
        r.status = s;
        return r;
    endfunction

    always_comb begin
        ubhf_pkg::t_res [ubhf_pkg::MAX_RES-1:0] res;
        logic [2:0]  k;
        logic [7:0]  b;
        logic [7:0]  opc;
        logic [7:0]  cnt;
        logic [8:0]  cl_dec;
        logic [15:0] rem_dec;
        logic [15:0] wt_inc;
        logic [8:0]  rc_inc;
        logic        fin;
        logic [1:0]  fin_st;
        logic [7:0]  fin_val;
        logic        chunk;
        logic [15:0] chunk_rem;
        n_phase = r_phase;
        n_op = r_op;
        n_addr = r_addr;
        n_rem = r_rem;
        n_cl = r_cl;
        n_sum = r_sum;
        n_rc = r_rc;
        n_ver = r_ver;
        n_wt = r_wt;
        res = '0;
        k = '0;
        b = i_in.data_byte;
        cnt = 8'(r_cl - 9'd1);
        cl_dec = r_cl - 9'd1;
        rem_dec = r_rem - 16'd1;
        wt_inc = (r_wt < 16'hFFFF) ? r_wt + 16'd1 : r_wt;
        rc_inc = r_rc + 9'd1;
        fin = 1'b0;
        fin_st = ubhf_pkg::ST_OK;
        fin_val = '0;
        chunk = 1'b0;
        chunk_rem = r_rem;
        opc = '0;

        if (i_in.cmd <= ubhf_pkg::CMD_START_READ && r_phase != ubhf_pkg::PH_IDLE) begin
            res[k] = f_res(ubhf_pkg::KIND_FINISH, 8'd0, 9'd0, ubhf_pkg::ST_UNEXP);
            k = k + 3'd1;
        end else begin
            unique case (i_in.cmd)
                ubhf_pkg::CMD_SYNC: begin
                    n_op = ubhf_pkg::OP_SYNC;
                    n_phase = ubhf_pkg::PH_SYNC_ACK;
                    n_wt = '0;
                    res[k] = f_res(ubhf_pkg::KIND_TX, ubhf_pkg::SYNC_BYTE, 9'd0, ubhf_pkg::ST_OK);
                    k = k + 3'd1;
                end
                ubhf_pkg::CMD_GET: begin
                    n_op = ubhf_pkg::OP_GET;
                    n_phase = ubhf_pkg::PH_GET_ACK;
                    n_ver = '0;
                    n_wt = '0;
                    res[k] = f_res(ubhf_pkg::KIND_TX, i_cfg.get_opcode, 9'd0, ubhf_pkg::ST_OK);
                    k = k + 3'd1;
                    res[k] = f_res(ubhf_pkg::KIND_TX, ~i_cfg.get_opcode, 9'd0, ubhf_pkg::ST_OK);
                    k = k + 3'd1;
                end
                ubhf_pkg::CMD_ERASE: begin
                    n_op = ubhf_pkg::OP_ERASE;
                    n_phase = ubhf_pkg::PH_ERASE_ACK1;
                    n_wt = '0;
                    res[k] = f_res(ubhf_pkg::KIND_TX, i_cfg.erase_opcode, 9'd0,
                                   ubhf_pkg::ST_OK);
                    k = k + 3'd1;
                    res[k] = f_res(ubhf_pkg::KIND_TX, ~i_cfg.erase_opcode, 9'd0,
                                   ubhf_pkg::ST_OK);
                    k = k + 3'd1;
                end
                ubhf_pkg::CMD_START_WRITE, ubhf_pkg::CMD_START_READ: begin
                    if (i_in.length == 16'd0) begin
                        fin = 1'b1;
                    end else begin
                        n_op = (i_in.cmd == ubhf_pkg::CMD_START_WRITE) ?
                               ubhf_pkg::OP_WRITE : ubhf_pkg::OP_READ;
                        n_addr = i_in.address;
                        n_rem = i_in.length;
                        chunk = 1'b1;
                        chunk_rem = i_in.length;
                    end
                end
                ubhf_pkg::CMD_WRITE_BYTE: begin
                    if (r_phase != ubhf_pkg::PH_WDATA) begin
                        res[k] = f_res(ubhf_pkg::KIND_FINISH, 8'd0, 9'd0, ubhf_pkg::ST_UNEXP);
                        k = k + 3'd1;
                    end else begin
                        res[k] = f_res(ubhf_pkg::KIND_TX, b, 9'd0, ubhf_pkg::ST_OK);
                        k = k + 3'd1;
                        n_sum = r_sum ^ b;
                        n_addr = r_addr + 32'd1;
                        n_rem = rem_dec;
                        n_cl = cl_dec;
                        if (cl_dec == 9'd0) begin
                            res[k] = f_res(ubhf_pkg::KIND_TX, r_sum ^ b, 9'd0, ubhf_pkg::ST_OK);
                            k = k + 3'd1;
                            n_phase = ubhf_pkg::PH_WSUM_ACK;
                            n_wt = '0;
                        end
                    end
                end
                ubhf_pkg::CMD_TARGET_BYTE: begin
                    if (r_phase == ubhf_pkg::PH_IDLE || r_phase == ubhf_pkg::PH_WDATA) begin
                        res[k] = f_res(ubhf_pkg::KIND_FINISH, 8'd0, 9'd0, ubhf_pkg::ST_UNEXP);
                        k = k + 3'd1;
                    end else begin
                        n_wt = '0;
                        unique case (r_phase)
                            ubhf_pkg::PH_GET_N: begin
                                n_cl = {1'b0, b} + 9'd1;
                                n_rc = '0;
                                n_phase = ubhf_pkg::PH_GET_BODY;
                            end
                            ubhf_pkg::PH_GET_BODY: begin
                                if (r_rc == 9'd0) n_ver = b;
                                n_rc = rc_inc;
                                if (rc_inc >= r_cl) n_phase = ubhf_pkg::PH_GET_END_ACK;
                            end
                            ubhf_pkg::PH_RDATA: begin
                                res[k] = f_res(ubhf_pkg::KIND_RDATA, b, 9'd0, ubhf_pkg::ST_OK);
                                k = k + 3'd1;
                                n_addr = r_addr + 32'd1;
                                n_rem = rem_dec;
                                n_cl = cl_dec;
                                if (cl_dec == 9'd0) begin
                                    if (rem_dec != 16'd0) begin
                                        chunk = 1'b1;
                                        chunk_rem = rem_dec;
                                    end else begin
                                        fin = 1'b1;
                                    end
                                end
                            end
                            default: begin
                                if (b != i_cfg.ack_value) begin
                                    fin = 1'b1;
                                    fin_st = ubhf_pkg::ST_NACK;
                                end else begin
                                    unique case (r_phase)
                                        ubhf_pkg::PH_GET_ACK: n_phase = ubhf_pkg::PH_GET_N;
                                        ubhf_pkg::PH_GET_END_ACK: begin
                                            fin = 1'b1;
                                            fin_val = r_ver;
                                        end
                                        ubhf_pkg::PH_ERASE_ACK1: begin
                                            res[k] = f_res(ubhf_pkg::KIND_TX, 8'hFF, 9'd0,
                                                           ubhf_pkg::ST_OK);
                                            k = k + 3'd1;
                                            res[k] = f_res(ubhf_pkg::KIND_TX, 8'h00, 9'd0,
                                                           ubhf_pkg::ST_OK);
                                            k = k + 3'd1;
                                            n_phase = ubhf_pkg::PH_ERASE_ACK2;
                                        end
                                        ubhf_pkg::PH_CMD_ACK: begin
                                            res[k] = f_res(ubhf_pkg::KIND_TX, r_addr[31:24],
                                                           9'd0, ubhf_pkg::ST_OK);
                                            k = k + 3'd1;
                                            res[k] = f_res(ubhf_pkg::KIND_TX, r_addr[23:16],
                                                           9'd0, ubhf_pkg::ST_OK);
                                            k = k + 3'd1;
                                            res[k] = f_res(ubhf_pkg::KIND_TX, r_addr[15:8],
                                                           9'd0, ubhf_pkg::ST_OK);
                                            k = k + 3'd1;
                                            res[k] = f_res(ubhf_pkg::KIND_TX, r_addr[7:0],
                                                           9'd0, ubhf_pkg::ST_OK);
                                            k = k + 3'd1;
                                            res[k] = f_res(ubhf_pkg::KIND_TX,
                                                           r_addr[31:24] ^ r_addr[23:16] ^
                                                           r_addr[15:8] ^ r_addr[7:0],
                                                           9'd0, ubhf_pkg::ST_OK);
                                            k = k + 3'd1;
                                            n_phase = ubhf_pkg::PH_ADDR_ACK;
                                        end
                                        ubhf_pkg::PH_ADDR_ACK: begin
                                            res[k] = f_res(ubhf_pkg::KIND_TX, cnt, 9'd0,
                                                           ubhf_pkg::ST_OK);
                                            k = k + 3'd1;
                                            if (r_op == ubhf_pkg::OP_READ) begin
                                                res[k] = f_res(ubhf_pkg::KIND_TX, ~cnt, 9'd0,
                                                               ubhf_pkg::ST_OK);
                                                k = k + 3'd1;
                                                n_phase = ubhf_pkg::PH_RLEN_ACK;
                                            end else begin
                                                n_sum = cnt;
                                                res[k] = f_res(ubhf_pkg::KIND_REQ, 8'd0, r_cl,
                                                               ubhf_pkg::ST_OK);
                                                k = k + 3'd1;
                                                n_phase = ubhf_pkg::PH_WDATA;
                                            end
                                        end
                                        ubhf_pkg::PH_RLEN_ACK: n_phase = ubhf_pkg::PH_RDATA;
                                        ubhf_pkg::PH_WSUM_ACK: begin
                                            if (r_rem != 16'd0) chunk = 1'b1;
                                            else fin = 1'b1;
                                        end
                                        default: fin = 1'b1;
                                    endcase
                                end
                            end
                        endcase
                    end
                end
                default: begin
                    if (r_phase != ubhf_pkg::PH_IDLE && r_phase != ubhf_pkg::PH_WDATA) begin
                        n_wt = wt_inc;
                        if (wt_inc >= i_cfg.reply_timeout) begin
                            fin = 1'b1;
                            fin_st = ubhf_pkg::ST_TIMEOUT;
                        end
                    end
                end
            endcase
        end

        if (chunk) begin
            opc = (n_op == ubhf_pkg::OP_WRITE) ? i_cfg.write_opcode : i_cfg.read_opcode;
            n_cl = f_chunk(chunk_rem);
            n_phase = ubhf_pkg::PH_CMD_ACK;
            n_wt = '0;
            res[k] = f_res(ubhf_pkg::KIND_TX, opc, 9'd0, ubhf_pkg::ST_OK);
            k = k + 3'd1;
            res[k] = f_res(ubhf_pkg::KIND_TX, ~opc, 9'd0, ubhf_pkg::ST_OK);
            k = k + 3'd1;
        end
        if (fin) begin
            n_phase = ubhf_pkg::PH_IDLE;
            n_op = ubhf_pkg::OP_NONE;
            n_wt = '0;
            res[k] = f_res(ubhf_pkg::KIND_FINISH, fin_val, 9'd0, fin_st);
            k = k + 3'd1;
        end
        o_pkt.count = k;
        o_pkt.res = res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= ubhf_pkg::PH_IDLE;
            r_op <= ubhf_pkg::OP_NONE;
            r_addr <= '0;
            r_rem <= '0;
            r_cl <= '0;
            r_sum <= '0;
            r_rc <= '0;
            r_ver <= '0;
            r_wt <= '0;
        end else if (i_take) begin
            r_phase <= n_phase;
            r_op <= n_op;
            r_addr <= n_addr;
            r_rem <= n_rem;
            r_cl <= n_cl;
            r_sum <= n_sum;
            r_rc <= n_rc;
            r_ver <= n_ver;
            r_wt <= n_wt;
        end
    end

endmodule

/* hw/rtl/ubhf_queue.sv */
// two-entry packet queue between front and back
// depends on ubhf_pkg
module ubhf_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  ubhf_pkg::t_pkt i_pkt,
    input  logic           i_pop,
    output ubhf_pkg::t_pkt o_head,
    output logic [1:0]     o_level
);

    ubhf_pkg::t_pkt r_mem [2];
    logic r_wp, r_rp;
    logic [1:0] r_level;

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_pkt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_level <= '0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop) r_rp <= ~r_rp;
            r_level <= r_level + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

    assign o_head = r_mem[r_rp];
    assign o_level = r_level;

endmodule

/* hw/rtl/ubhf_back.sv */
// back part: plays out the words of the head packet one per cycle while i_ready is high
// depends on ubhf_pkg
module ubhf_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  ubhf_pkg::t_pkt i_head,
    input  logic           i_head_valid,
    input  logic           i_ready,
    output logic           o_pop,
    output logic           o_valid,
    output ubhf_pkg::t_out o_out
);

    logic [2:0] r_idx;
    logic last;
    ubhf_pkg::t_res cur;

    assign cur = i_head.res[r_idx];
    assign last = (r_idx == i_head.count - 3'd1);
    assign o_valid = i_head_valid;
    assign o_pop = i_head_valid && i_ready && last;

    always_comb begin
        o_out.kind = cur.kind;
        o_out.value = cur.value;
        o_out.chunk_length = cur.chunk_length;
        o_out.status = cur.status;
        o_out.last = last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else if (i_head_valid && i_ready) begin
            r_idx <= last ? 3'd0 : r_idx + 3'd1;
        end
    end

endmodule

/* hw/rtl/uart_bootloader_host_framer_top.sv */
// top level of the bootloader host framer: config registers, front, queue, back
// depends on ubhf_pkg, ubhf_front, ubhf_queue, ubhf_back, assert_macros.svh
//
// channel  direction  handshake                 payload
// in       input      i_in_valid / o_in_ready   i_in  (t_in)
// out      output     o_out_valid / i_out_ready o_out (t_out)
// cfg      input      i_cfg_we                  i_cfg_idx, i_cfg_data
//
// one input word accepted per cycle while the two-entry queue has room
// each input word gives 0 to 5 output words, played out one per ready cycle
// protocol state updates in the cycle the word is accepted
// synchronous active-low reset empties the queue and returns to idle
`include "assert_macros.svh"
module uart_bootloader_host_framer_top #(
    parameter int CHUNK_MAX = 256
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  ubhf_pkg::t_in  i_in,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output ubhf_pkg::t_out o_out,
    input  logic           i_cfg_we,
    input  logic [2:0]     i_cfg_idx,
    input  logic [15:0]    i_cfg_data
);

    ubhf_pkg::t_cfg r_cfg;
    ubhf_pkg::t_pkt pkt, head;
    logic [1:0] level;
    logic take, push, pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ack_value <= 8'h79;
            r_cfg.get_opcode <= 8'h00;
            r_cfg.read_opcode <= 8'h11;
            r_cfg.write_opcode <= 8'h31;
            r_cfg.erase_opcode <= 8'h43;
            r_cfg.reply_timeout <= 16'd300;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                ubhf_pkg::REG_ACK:      r_cfg.ack_value <= i_cfg_data[7:0];
                ubhf_pkg::REG_GET_OP:   r_cfg.get_opcode <= i_cfg_data[7:0];
                ubhf_pkg::REG_READ_OP:  r_cfg.read_opcode <= i_cfg_data[7:0];
                ubhf_pkg::REG_WRITE_OP: r_cfg.write_opcode <= i_cfg_data[7:0];
                ubhf_pkg::REG_ERASE_OP: r_cfg.erase_opcode <= i_cfg_data[7:0];
                ubhf_pkg::REG_TIMEOUT:  r_cfg.reply_timeout <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_in_ready = (level != 2'd2);
    assign take = i_in_valid && o_in_ready;
    assign push = take && (pkt.count != 3'd0);

    ubhf_front #(.CHUNK_MAX(CHUNK_MAX)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_in    (i_in),
        .i_take  (take),
        .o_pkt   (pkt)
    );

    ubhf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pkt   (pkt),
        .i_pop   (pop),
        .o_head  (head),
        .o_level (level)
    );

    ubhf_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (head),
        .i_head_valid (level != 2'd0),
        .i_ready      (i_out_ready),
        .o_pop        (pop),
        .o_valid      (o_out_valid),
        .o_out        (o_out)
    );

    `ASSERT_CLK(a_full_blocks, (level == 2'd2) |-> !o_in_ready, "input taken with queue full")
    `ASSERT_CLK(a_level_range, level != 2'd3, "queue level overflow")
    `ASSERT_CLK(a_burst_holds, (o_out_valid && i_out_ready && !o_out.last) |=> o_out_valid, "packet cut short")
    `ASSERT_CLK(a_head_nonempty, o_out_valid |-> (head.count != 3'd0), "empty packet queued")

endmodule

/* tb/sv/tb_top.sv */
// self-checking testbench of the bootloader host framer
// depends on ubhf_pkg and uart_bootloader_host_framer_top; predicts every output word
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 3000000;

    logic           i_clk = 1'b0;
    logic           i_rst_n = 1'b0;
    logic           in_valid = 1'b0;
    logic           o_in_ready;
    ubhf_pkg::t_in  in_word = '0;
    logic           o_out_valid;
    logic           out_ready = 1'b0;
    ubhf_pkg::t_out o_out;
    logic           cfg_we = 1'b0;
    logic [2:0]     cfg_idx = '0;
    logic [15:0]    cfg_data = '0;

    uart_bootloader_host_framer_top i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .o_in_ready(o_in_ready), .i_in(in_word),
        .o_out_valid(o_out_valid), .i_out_ready(out_ready), .o_out(o_out),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data)
    );

    always #6 i_clk = ~i_clk;

    // framer prediction state
    ubhf_pkg::t_cfg   cur_cfg;
    ubhf_pkg::t_phase p_phase;
    logic [2:0]  p_op;
    logic [31:0] p_addr;
    logic [15:0] p_remain;
    logic [8:0]  p_chunk;
    logic [7:0]  p_sum;
    logic [8:0]  p_cnt;
    logic [7:0]  p_ver;
    logic [15:0] p_timer;

    ubhf_pkg::t_out expected_words[$];
    ubhf_pkg::t_out burst[$];
    int   fails = 0;
    int   cycles = 0;
    bit   quiet = 0;
    bit   hold_rx = 0;

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    function automatic ubhf_pkg::t_in mk(int c, int a, int l, int d);
        ubhf_pkg::t_in w;
        w.cmd = 3'(c); w.address = 32'(a); w.length = 16'(l); w.data_byte = 8'(d);
        return w;
    endfunction

    task automatic put(logic [1:0] k, logic [7:0] v, logic [8:0] c, logic [1:0] s);
        ubhf_pkg::t_out o;
        o.kind = k; o.value = v; o.chunk_length = c; o.status = s; o.last = 1'b0;
        burst.push_back(o);
    endtask

    task automatic finish_op(logic [1:0] s, logic [7:0] v);
        p_phase = ubhf_pkg::PH_IDLE;
        p_op = ubhf_pkg::OP_NONE;
        p_timer = '0;
        put(ubhf_pkg::KIND_FINISH, v, 9'd0, s);
    endtask

    task automatic send_opcode(logic [7:0] op);
        put(ubhf_pkg::KIND_TX, op, 9'd0, ubhf_pkg::ST_OK);
        put(ubhf_pkg::KIND_TX, 8'hFF - op, 9'd0, ubhf_pkg::ST_OK);
    endtask

    task automatic start_chunk();
        p_chunk = (p_remain > 16'd256) ? 9'd256 : p_remain[8:0];
        p_phase = ubhf_pkg::PH_CMD_ACK;
        p_timer = '0;
        send_opcode(p_op == ubhf_pkg::OP_WRITE ? cur_cfg.write_opcode : cur_cfg.read_opcode);
    endtask

    task automatic on_ack();
        logic [7:0] cnt;
        logic [7:0] x;
        cnt = 8'(p_chunk - 9'd1);
        x = p_addr[31:24] ^ p_addr[23:16] ^ p_addr[15:8] ^ p_addr[7:0];
        case (p_phase)
            ubhf_pkg::PH_SYNC_ACK, ubhf_pkg::PH_ERASE_ACK2: finish_op(ubhf_pkg::ST_OK, 8'd0);
            ubhf_pkg::PH_GET_ACK: p_phase = ubhf_pkg::PH_GET_N;
            ubhf_pkg::PH_GET_END_ACK: finish_op(ubhf_pkg::ST_OK, p_ver);
            ubhf_pkg::PH_ERASE_ACK1: begin
                put(ubhf_pkg::KIND_TX, 8'hFF, 9'd0, ubhf_pkg::ST_OK);
                put(ubhf_pkg::KIND_TX, 8'h00, 9'd0, ubhf_pkg::ST_OK);
                p_phase = ubhf_pkg::PH_ERASE_ACK2;
            end
            ubhf_pkg::PH_CMD_ACK: begin
                put(ubhf_pkg::KIND_TX, p_addr[31:24], 9'd0, ubhf_pkg::ST_OK);
                put(ubhf_pkg::KIND_TX, p_addr[23:16], 9'd0, ubhf_pkg::ST_OK);
                put(ubhf_pkg::KIND_TX, p_addr[15:8], 9'd0, ubhf_pkg::ST_OK);
                put(ubhf_pkg::KIND_TX, p_addr[7:0], 9'd0, ubhf_pkg::ST_OK);
                put(ubhf_pkg::KIND_TX, x, 9'd0, ubhf_pkg::ST_OK);
                p_phase = ubhf_pkg::PH_ADDR_ACK;
            end
            ubhf_pkg::PH_ADDR_ACK: begin
                put(ubhf_pkg::KIND_TX, cnt, 9'd0, ubhf_pkg::ST_OK);
                if (p_op == ubhf_pkg::OP_READ) begin
                    put(ubhf_pkg::KIND_TX, 8'hFF - cnt, 9'd0, ubhf_pkg::ST_OK);
                    p_phase = ubhf_pkg::PH_RLEN_ACK;
                end else begin
                    p_sum = cnt;
                    put(ubhf_pkg::KIND_REQ, 8'd0, p_chunk, ubhf_pkg::ST_OK);
                    p_phase = ubhf_pkg::PH_WDATA;
                end
            end
            ubhf_pkg::PH_RLEN_ACK: p_phase = ubhf_pkg::PH_RDATA;
            default: begin
                if (p_remain > 16'd0) start_chunk();
                else finish_op(ubhf_pkg::ST_OK, 8'd0);
            end
        endcase
    endtask

    task automatic on_target(logic [7:0] b);
        p_timer = '0;
        case (p_phase)
            ubhf_pkg::PH_GET_N: begin
                p_chunk = {1'b0, b} + 9'd1;
                p_cnt = '0;
                p_phase = ubhf_pkg::PH_GET_BODY;
            end
            ubhf_pkg::PH_GET_BODY: begin
                if (p_cnt == 9'd0) p_ver = b;
                p_cnt = p_cnt + 9'd1;
                if (p_cnt >= p_chunk) p_phase = ubhf_pkg::PH_GET_END_ACK;
            end
            ubhf_pkg::PH_RDATA: begin
                put(ubhf_pkg::KIND_RDATA, b, 9'd0, ubhf_pkg::ST_OK);
                p_addr = p_addr + 32'd1;
                p_remain = p_remain - 16'd1;
                p_chunk = p_chunk - 9'd1;
                if (p_chunk == 9'd0) begin
                    if (p_remain > 16'd0) start_chunk();
                    else finish_op(ubhf_pkg::ST_OK, 8'd0);
                end
            end
            default: begin
                if (b != cur_cfg.ack_value) finish_op(ubhf_pkg::ST_NACK, 8'd0);
                else on_ack();
            end
        endcase
    endtask

    task automatic predict_framer(ubhf_pkg::t_in w);
        burst.delete();
        if (w.cmd <= ubhf_pkg::CMD_START_READ && p_phase != ubhf_pkg::PH_IDLE) begin
            put(ubhf_pkg::KIND_FINISH, 8'd0, 9'd0, ubhf_pkg::ST_UNEXP);
        end else begin
            case (w.cmd)
                ubhf_pkg::CMD_SYNC: begin
                    p_op = ubhf_pkg::OP_SYNC; p_phase = ubhf_pkg::PH_SYNC_ACK; p_timer = '0;
                    put(ubhf_pkg::KIND_TX, ubhf_pkg::SYNC_BYTE, 9'd0, ubhf_pkg::ST_OK);
                end
                ubhf_pkg::CMD_GET: begin
                    p_op = ubhf_pkg::OP_GET; p_phase = ubhf_pkg::PH_GET_ACK;
                    p_ver = '0; p_timer = '0;
                    send_opcode(cur_cfg.get_opcode);
                end
                ubhf_pkg::CMD_ERASE: begin
                    p_op = ubhf_pkg::OP_ERASE; p_phase = ubhf_pkg::PH_ERASE_ACK1; p_timer = '0;
                    send_opcode(cur_cfg.erase_opcode);
                end
                ubhf_pkg::CMD_START_WRITE, ubhf_pkg::CMD_START_READ: begin
                    if (w.length == 16'd0) begin
                        finish_op(ubhf_pkg::ST_OK, 8'd0);
                    end else begin
                        p_op = (w.cmd == ubhf_pkg::CMD_START_WRITE) ?
                               ubhf_pkg::OP_WRITE : ubhf_pkg::OP_READ;
                        p_addr = w.address;
                        p_remain = w.length;
                        start_chunk();
                    end
                end
                ubhf_pkg::CMD_WRITE_BYTE: begin
                    if (p_phase != ubhf_pkg::PH_WDATA) begin
                        put(ubhf_pkg::KIND_FINISH, 8'd0, 9'd0, ubhf_pkg::ST_UNEXP);
                    end else begin
                        put(ubhf_pkg::KIND_TX, w.data_byte, 9'd0, ubhf_pkg::ST_OK);
                        p_sum = p_sum ^ w.data_byte;
                        p_addr = p_addr + 32'd1;
                        p_remain = p_remain - 16'd1;
                        p_chunk = p_chunk - 9'd1;
                        if (p_chunk == 9'd0) begin
                            put(ubhf_pkg::KIND_TX, p_sum, 9'd0, ubhf_pkg::ST_OK);
                            p_phase = ubhf_pkg::PH_WSUM_ACK;
                            p_timer = '0;
                        end
                    end
                end
                ubhf_pkg::CMD_TARGET_BYTE: begin
                    if (p_phase == ubhf_pkg::PH_IDLE || p_phase == ubhf_pkg::PH_WDATA)
                        put(ubhf_pkg::KIND_FINISH, 8'd0, 9'd0, ubhf_pkg::ST_UNEXP);
                    else
                        on_target(w.data_byte);
                end
                default: begin
                    if (p_phase != ubhf_pkg::PH_IDLE && p_phase != ubhf_pkg::PH_WDATA) begin
                        if (p_timer < 16'hFFFF) p_timer = p_timer + 16'd1;
                        if (p_timer >= cur_cfg.reply_timeout)
                            finish_op(ubhf_pkg::ST_TIMEOUT, 8'd0);
                    end
                end
            endcase
        end
        if (burst.size() > 0) burst[burst.size()-1].last = 1'b1;
        foreach (burst[i]) expected_words.push_back(burst[i]);
    endtask

    task automatic send_word(ubhf_pkg::t_in w);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_word <= w;
        do @(posedge i_clk); while (!(in_valid && o_in_ready));
        predict_framer(w);
    endtask

    task automatic tgt(int b);
        send_word(mk(ubhf_pkg::CMD_TARGET_BYTE, $urandom, $urandom, b));
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (expected_words.size() > 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
    endtask

    // all six registers in one burst, block idle
    task automatic write_regs(ubhf_pkg::t_cfg c);
        logic [15:0] vals[6];
        vals[0] = {8'd0, c.ack_value};    vals[1] = {8'd0, c.get_opcode};
        vals[2] = {8'd0, c.read_opcode};  vals[3] = {8'd0, c.write_opcode};
        vals[4] = {8'd0, c.erase_opcode}; vals[5] = c.reply_timeout;
        drain();
        for (int i = 0; i < 6; i++) begin
            cfg_we <= 1'b1;
            cfg_idx <= 3'(i);
            cfg_data <= vals[i];
            @(posedge i_clk);
        end
        cfg_we <= 1'b0;
        cur_cfg = c;
    endtask

    // receive side and word check
    initial begin
        int stall;
        forever begin
            if (hold_rx) begin
                out_ready <= 1'b0;
                repeat (400) @(posedge i_clk);
                hold_rx = 0;
            end else begin
                stall = quiet ? 0 : $urandom_range(0, 19);
                if (stall > 0) begin
                    out_ready <= 1'b0;
                    repeat (stall) @(posedge i_clk);
                end
            end
            out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
            if (expected_words.size() == 0) begin
                $error("unexpected word kind=%0d value=%0h", o_out.kind, o_out.value);
                fails++;
            end else begin
                ubhf_pkg::t_out e;
                e = expected_words.pop_front();
                if (o_out.kind !== e.kind) begin
                    $error("kind exp %0d got %0d", e.kind, o_out.kind); fails++;
                end
                if (o_out.value !== e.value) begin
                    $error("value exp %0h got %0h", e.value, o_out.value); fails++;
                end
                if (o_out.chunk_length !== e.chunk_length) begin
                    $error("chunk_length exp %0d got %0d", e.chunk_length, o_out.chunk_length);
                    fails++;
                end
                if (o_out.status !== e.status) begin
                    $error("status exp %0d got %0d", e.status, o_out.status); fails++;
                end
                if (o_out.last !== e.last) begin
                    $error("last exp %0d got %0d", e.last, o_out.last); fails++;
                end
            end
        end
    end

    task automatic test_directed();
        logic [7:0] a;
        a = cur_cfg.ack_value;
        send_word(mk(ubhf_pkg::CMD_SYNC, 0, 0, 0)); tgt(a);
        send_word(mk(ubhf_pkg::CMD_GET, 0, 0, 0));
        tgt(a); tgt(8'd1); tgt(8'hA5); tgt(8'h5A); tgt(a);
        send_word(mk(ubhf_pkg::CMD_ERASE, 0, 0, 0)); tgt(a); tgt(a);
        send_word(mk(ubhf_pkg::CMD_START_WRITE, 32'hFFFF_FFFF, 2, 0)); tgt(a); tgt(a);
        send_word(mk(ubhf_pkg::CMD_WRITE_BYTE, 0, 0, 8'h00));
        send_word(mk(ubhf_pkg::CMD_WRITE_BYTE, 0, 0, 8'hFF));
        tgt(a);
        send_word(mk(ubhf_pkg::CMD_START_READ, 0, 1, 0)); tgt(a); tgt(a); tgt(a); tgt(8'hFF);
        send_word(mk(ubhf_pkg::CMD_START_WRITE, 32'h1234_5678, 0, 0));
        send_word(mk(ubhf_pkg::CMD_SYNC, 0, 0, 0)); send_word(mk(ubhf_pkg::CMD_GET, 0, 0, 0));
        tgt(~a);
        send_word(mk(ubhf_pkg::CMD_WRITE_BYTE, 0, 0, 8'h11)); tgt(8'h22);
        send_word(mk(ubhf_pkg::CMD_TICK, 0, 0, 0));
        drain();
    endtask

    task automatic test_timeout();
        ubhf_pkg::t_cfg c;
        c = cur_cfg;
        c.reply_timeout = 16'd2;
        write_regs(c);
        send_word(mk(ubhf_pkg::CMD_SYNC, 0, 0, 0));
        send_word(mk(ubhf_pkg::CMD_TICK, 0, 0, 0)); send_word(mk(ubhf_pkg::CMD_TICK, 0, 0, 0));
        send_word(mk(ubhf_pkg::CMD_ERASE, 0, 0, 0)); send_word(mk(ubhf_pkg::CMD_TICK, 0, 0, 0));
        tgt(cur_cfg.ack_value); send_word(mk(ubhf_pkg::CMD_TICK, 0, 0, 0));
        send_word(mk(ubhf_pkg::CMD_TICK, 0, 0, 0));
        drain();
    endtask

    task automatic test_random(int n_items);
        int sent, r, guard;
        logic [15:0] len;
        bit big;
        sent = 0;
        while (sent < n_items) begin
            r = $urandom_range(0, 99);
            big = 0;
            if (r < 80) len = 16'($urandom_range(1, 6));
            else if (r < 92) len = 16'($urandom_range(250, 300));
            else if (r < 95) len = 16'd0;
            else begin
                len = (r < 97) ? 16'hFFFF : 16'($urandom);
                big = (len > 16'd300);
            end
            send_word(mk($urandom_range(0, 4), $urandom, len, $urandom));
            sent++;
            guard = 0;
            while (p_phase != ubhf_pkg::PH_IDLE && guard < 800) begin
                r = $urandom_range(0, 99);
                guard++;
                sent++;
                case (p_phase)
                    ubhf_pkg::PH_WDATA: begin
                        if (r < 92)
                            send_word(mk(ubhf_pkg::CMD_WRITE_BYTE, $urandom, $urandom, $urandom));
                        else if (r < 95) tgt($urandom);
                        else if (r < 97)
                            send_word(mk(ubhf_pkg::CMD_TICK, $urandom, $urandom, $urandom));
                        else send_word(mk($urandom_range(0, 4), $urandom, $urandom, 0));
                    end
                    ubhf_pkg::PH_GET_N: begin
                        if (r < 90) tgt($urandom_range(0, 3));
                        else send_word(mk(ubhf_pkg::CMD_TICK, 0, 0, 0));
                    end
                    ubhf_pkg::PH_GET_BODY, ubhf_pkg::PH_RDATA: begin
                        if (r < 95) tgt($urandom);
                        else send_word(mk(ubhf_pkg::CMD_TICK, 0, 0, 0));
                    end
                    default: begin
                        if (big || (r >= 85 && r < 90)) tgt(~cur_cfg.ack_value);
                        else if (r < 85) tgt(cur_cfg.ack_value);
                        else if (r < 97) send_word(mk(ubhf_pkg::CMD_TICK, 0, 0, 0));
                        else send_word(mk($urandom_range(0, 4), $urandom, $urandom, 0));
                    end
                endcase
            end
            if ($urandom_range(0, 9) == 0) begin
                send_word(mk($urandom_range(5, 7), $urandom, $urandom, $urandom));
                sent++;
            end
        end
        drain();
    endtask

    task automatic test_backpressure();
        hold_rx = 1;
        send_word(mk(ubhf_pkg::CMD_START_READ, $urandom, 20, 0));
        tgt(cur_cfg.ack_value); tgt(cur_cfg.ack_value); tgt(cur_cfg.ack_value);
        for (int i = 0; i < 20; i++) tgt($urandom);
        drain();
    endtask

    initial begin
        ubhf_pkg::t_cfg c;
        cur_cfg = '{ack_value: 8'h79, get_opcode: 8'h00, read_opcode: 8'h11,
                    write_opcode: 8'h31, erase_opcode: 8'h43, reply_timeout: 16'd300};
        p_phase = ubhf_pkg::PH_IDLE; p_op = ubhf_pkg::OP_NONE; p_addr = '0; p_remain = '0;
        p_chunk = '0; p_sum = '0; p_cnt = '0; p_ver = '0; p_timer = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_timeout();
        test_backpressure();
        c = '{8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 16'd1};
        write_regs(c);
        test_random(40);
        c = '{8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 16'hFFFF};
        write_regs(c);
        quiet = 1;
        test_random(40);
        quiet = 0;
        c = '{8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 16'd6};
        write_regs(c);
        test_random(60);
        c = '{8'h79, 8'h00, 8'h11, 8'h31, 8'h43, 16'd300};
        write_regs(c);
        test_random(60);
        drain();
        if (fails == 0) $display("Verification passed");
        else $display("Verification failed");
        $finish;
    end

endmodule
